FILE: src/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
// No dependencies; imported by the matcher, the top level and the checker.
package wbps_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 16;
	localparam int OFFSET_BITS_DEF       = 32;
	localparam int PATTERN_BITS          = 128;
	localparam int MASK_BITS             = 16;
	localparam int LENGTH_BITS           = 5;
	localparam int CFG_DATA_BITS         = 64;
	localparam int CFG_INDEX_BITS        = 3;
	localparam int ADDR_BITS             = 64;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW    = 3'd0,
		REG_PATTERN_HIGH   = 3'd1,
		REG_WILDCARD_MASK  = 3'd2,
		REG_PATTERN_LENGTH = 3'd3,
		REG_REGION_BASE    = 3'd4
	} reg_index_t;

	// pattern bytes and wildcard bits as seen by the matcher
	typedef struct packed {
		logic [PATTERN_BITS-1:0] bytes;
		logic [MASK_BITS-1:0]    wild;
	} pattern_t;

endpackage

FILE: src/wbps_match.sv
// Parallel window compare: all pattern bytes against the byte window at once.
// Depends on wbps_pkg (pattern_t).
module wbps_match import wbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
	input  logic [7:0]                                 window [MAX_PATTERN_BYTES],
	input  pattern_t                                   pattern,
	input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]     length,
	output logic                                       hit
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [MAX_PATTERN_BYTES-1:0] miss;

	// pattern byte j lines up with the byte of age length-1-j
	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_byte
		localparam logic [LEN_W-1:0] JV = LEN_W'(j);
		logic [LEN_W-1:0] age;
		logic             active;
		logic [7:0]       sample;

		assign active  = JV < length;
		assign age     = length - JV - LEN_W'(1);
		assign sample  = window[age[IDX_W-1:0]];
		assign miss[j] = active && !pattern.wild[j] &&
			(sample != pattern.bytes[8*j +: 8]);
	end

	assign hit = ~|miss;

endmodule

FILE: src/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search: one byte transfer per cycle, full throughput while results are taken.
// A result passes the input register, then the result register, on its way
// to the output; one byte per cycle is sustained while results are taken,
// and the input stalls only when a result is held.
// Reset (arst_n low, asynchronous) empties both stages, clears the region
// state and sets pattern_length to 1, all other configuration registers to 0.
module wildcard_byte_pattern_search import wbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
	parameter int OFFSET_BITS       = OFFSET_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write port
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	// byte stream
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                data_byte,
	input  logic                      last_byte,
	// results
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      found,
	output logic [ADDR_BITS-1:0]      match_address
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

	// configuration registers
	logic [CFG_DATA_BITS-1:0] pattern_low_q;
	logic [CFG_DATA_BITS-1:0] pattern_high_q;
	logic [MASK_BITS-1:0]     wildcard_mask_q;
	logic [LENGTH_BITS-1:0]   pattern_length_q;
	logic [ADDR_BITS-1:0]     region_base_q;

	// input stage: window[0] is the byte in the stage, window[a] is a bytes older
	logic                     valid_s1;
	logic                     last_s1;
	logic [7:0]               window_s1 [MAX_PATTERN_BYTES];

	// region state
	logic [OFFSET_BITS-1:0]   bytes_seen_q;
	logic                     match_reported_q;

	// result register
	logic                     valid_s2;
	logic                     found_s2;
	logic [ADDR_BITS-1:0]     address_s2;

	logic [LEN_W-1:0]         eff_len;
	pattern_t                 pattern;
	logic                     window_hit;
	logic                     check_en;
	logic                     hit;
	logic                     emit;
	logic                     advance;
	logic                     accept;
	logic [ADDR_BITS-1:0]     hit_address;

	// Configuration writes. Indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			wildcard_mask_q  <= '0;
			pattern_length_q <= LENGTH_BITS'(1);
			region_base_q    <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				REG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				REG_WILDCARD_MASK:  wildcard_mask_q  <= cfg_data[MASK_BITS-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LENGTH_BITS-1:0];
				REG_REGION_BASE:    region_base_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the length: zero acts as one, anything past the window as its size.
	always_comb begin
		if (pattern_length_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (pattern_length_q > LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
			eff_len = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			eff_len = LEN_W'(pattern_length_q);
		end
	end

	assign pattern.bytes = {pattern_high_q, pattern_low_q};
	assign pattern.wild  = wildcard_mask_q;

	wbps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_match (
		.window  (window_s1),
		.pattern (pattern),
		.length  (eff_len),
		.hit     (window_hit)
	);

	// A window counts only once it holds bytes of this region alone, no match
	// was reported yet, and the offset counter has not saturated.
	assign check_en = !match_reported_q && (bytes_seen_q != OFFSET_MAX) &&
		(bytes_seen_q >= OFFSET_BITS'(eff_len - LEN_W'(1)));
	assign hit  = check_en && window_hit;
	// Not found goes out only on the last byte of a region with no match.
	assign emit = hit || (last_s1 && !match_reported_q);

	// Start offset is bytes_seen - (len - 1); wraps modulo 2^64 with the base.
	assign hit_address = region_base_q + ADDR_BITS'(bytes_seen_q) -
		ADDR_BITS'(eff_len) + ADDR_BITS'(1);

	// The stage moves on when the result register is free or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// Input stage: every transfer shifts the window; old bytes of a previous
	// region are masked by the bytes_seen check, so no clear is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			for (int a = 0; a < MAX_PATTERN_BYTES; a++) begin
				window_s1[a] <= '0;
			end
		end else begin
			if (accept) begin
				valid_s1     <= 1'b1;
				last_s1      <= last_byte;
				window_s1[0] <= data_byte;
				for (int a = 1; a < MAX_PATTERN_BYTES; a++) begin
					window_s1[a] <= window_s1[a-1];
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Region state: advance per byte, drop everything on the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q     <= '0;
			match_reported_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				bytes_seen_q     <= '0;
				match_reported_q <= 1'b0;
			end else begin
				if (hit) begin
					match_reported_q <= 1'b1;
				end
				if (bytes_seen_q != OFFSET_MAX) begin
					bytes_seen_q <= bytes_seen_q + OFFSET_BITS'(1);
				end
			end
		end
	end

	// Result register: load on a result, hold until the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= emit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			found_s2   <= hit;
			address_s2 <= hit ? hit_address : '0;
		end
	end

	assign out_valid     = valid_s2;
	assign found         = found_s2;
	assign match_address = address_s2;

endmodule

FILE: src/wbps_checker.sv
// Port-level checks for the wildcard byte pattern search block.
// Depends on wbps_pkg; attached to the top level by the bind below.
module wbps_checker import wbps_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [7:0]                data_byte,
	input logic                      last_byte,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      found,
	input logic [ADDR_BITS-1:0]      match_address
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_address))
		else $error("result changed while stalled");

	// a not-found result carries address zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_address == '0)
		else $error("not-found result with nonzero address");

	// input stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a held result");

	// a fresh result is preceded by a byte transfer through the input stage
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding byte");

	// a stalled byte holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(data_byte) && $stable(last_byte))
		else $error("byte changed while stalled");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (.*);

FILE: tb/sv/wildcard_byte_pattern_search_tb.sv
// Self-checking testbench for wildcard_byte_pattern_search: byte regions in, match reports out.
// A behavioral search model predicts each report at the byte transfer; a monitor checks them.
// Depends on wbps_pkg and the wildcard_byte_pattern_search RTL only.
module wildcard_byte_pattern_search_tb;
	import wbps_pkg::*;

	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 6;              // two-stage pipeline plus margin
	localparam int HISTORY_BYTES = MAX_PATTERN_BYTES_DEF - 1;
	localparam logic [OFFSET_BITS_DEF-1:0] SEEN_MAX = '1;

	typedef struct packed {
		logic                 found;
		logic [ADDR_BITS-1:0] address;
	} search_report_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_PATTERN_LOW;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [7:0]                data_byte = 8'h00;
	logic                      last_byte = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      found;
	logic [ADDR_BITS-1:0]      match_address;

	// expected match reports, oldest first
	search_report_t expected_reports [$];

	// shadow of the configuration registers
	logic [PATTERN_BITS-1:0] pattern_shadow = '0;
	logic [MASK_BITS-1:0]    mask_shadow = '0;
	logic [LENGTH_BITS-1:0]  length_shadow = 5'd1;
	logic [ADDR_BITS-1:0]    base_shadow = '0;

	// shadow of the region state
	logic [7:0]                 history [0:HISTORY_BYTES-1];
	logic [OFFSET_BITS_DEF-1:0] seen_count = '0;
	logic                       match_done = 1'b0;

	logic [7:0] region_buf [$];
	int mismatch_count = 0;
	int bytes_sent = 0;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	int calm_cycles = 0;
	bit no_gap = 1'b0;

	wildcard_byte_pattern_search uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.match_address (match_address)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Result side: stall at the phase rate, with occasional calm stretches that never stall.
	always @(posedge clk) begin
		if (calm_cycles != 0) begin
			out_ready <= 1'b1;
			calm_cycles = calm_cycles - 1;
		end else begin
			if ($urandom_range(0, 255) == 0)
				calm_cycles = 40;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (mismatch_count < 40)
			$display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got,
				cycle_count);
		mismatch_count++;
	endtask

	// Compare every result transfer with the oldest expected report.
	always @(posedge clk) begin : check_results
		search_report_t head;
		if (arst_n && out_valid && out_ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected result", 64'd0, match_address);
			end else begin
				head = expected_reports.pop_front();
				if (found !== head.found)
					report_mismatch("found", 64'(head.found), 64'(found));
				if (match_address !== head.address)
					report_mismatch("match_address", head.address, match_address);
			end
		end
	end

	// Pattern length in use: zero acts as one, anything past the maximum as the maximum.
	function automatic int active_length();
		if (length_shadow == 0)
			return 1;
		if (length_shadow > MAX_PATTERN_BYTES_DEF)
			return MAX_PATTERN_BYTES_DEF;
		return int'(length_shadow);
	endfunction

	function automatic void clear_region_state();
		for (int j = 0; j < HISTORY_BYTES; j++)
			history[j] = 8'h00;
		seen_count = '0;
		match_done = 1'b0;
	endfunction

	// Advance the search model by one byte transfer and queue any report it gives.
	function automatic void search_step(input logic [7:0] value, input logic is_last);
		int len;
		int k;
		bit hit;
		logic [7:0] cand;
		search_report_t rep;
		len = active_length();
		// Windows start only once enough region bytes are in; a saturated offset starts none.
		if (!match_done && seen_count < SEEN_MAX && 64'(seen_count) + 1 >= 64'(len)) begin
			hit = 1'b1;
			for (int j = 0; j < len; j++) begin
				k = len - 1 - j;  // age of the byte, zero is the current one
				cand = (k == 0) ? value : history[k-1];
				if (!mask_shadow[j] && cand != pattern_shadow[8*j +: 8])
					hit = 1'b0;
			end
			if (hit) begin
				rep.found = 1'b1;
				rep.address = base_shadow + 64'(seen_count) - 64'(len - 1);
				expected_reports.insert(expected_reports.size(), rep);
				match_done = 1'b1;
			end
		end
		if (is_last) begin
			if (!match_done) begin
				rep.found = 1'b0;
				rep.address = '0;
				expected_reports.insert(expected_reports.size(), rep);
			end
			clear_region_state();
		end else begin
			for (int j = HISTORY_BYTES - 1; j > 0; j--)
				history[j] = history[j-1];
			history[0] = value;
			if (seen_count < SEEN_MAX)
				seen_count = seen_count + 1;
		end
	endfunction

	// Hold valid high until the byte transfers; idle first at the phase rate.
	task automatic send_byte(input logic [7:0] value, input logic is_last);
		while (!no_gap && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= value;
		last_byte <= is_last;
		do
			@(posedge clk);
		while (!in_ready);
		search_step(value, is_last);
		bytes_sent++;
	endtask

	// Drop valid and wait until every expected report is in and the pipeline is empty.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Only called with the block idle; the trailing wait keeps cfg_write to one update per step.
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_PATTERN_LOW:    pattern_shadow[63:0] = value;
			REG_PATTERN_HIGH:   pattern_shadow[127:64] = value;
			REG_WILDCARD_MASK:  mask_shadow = value[MASK_BITS-1:0];
			REG_PATTERN_LENGTH: length_shadow = value[LENGTH_BITS-1:0];
			REG_REGION_BASE:    base_shadow = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_search(input logic [PATTERN_BITS-1:0] pattern,
			input logic [63:0] mask, input logic [63:0] len, input logic [63:0] base);
		drain_results();
		write_reg(REG_PATTERN_LOW, pattern[63:0]);
		write_reg(REG_PATTERN_HIGH, pattern[127:64]);
		write_reg(REG_WILDCARD_MASK, mask);
		write_reg(REG_PATTERN_LENGTH, len);
		write_reg(REG_REGION_BASE, base);
	endtask

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Send region_buf as one region; optionally pause after byte split_at and rewrite a register.
	task automatic send_region(input int split_at);
		for (int i = 0; i < region_buf.size(); i++) begin
			send_byte(region_buf[i], i == region_buf.size() - 1);
			if (i == split_at) begin
				drain_results();
				case ($urandom_range(0, 4))
					0: write_reg(REG_PATTERN_LOW, random_word());
					1: write_reg(REG_PATTERN_HIGH, random_word());
					2: write_reg(REG_WILDCARD_MASK, 64'($urandom & $urandom));
					3: write_reg(REG_PATTERN_LENGTH, 64'($urandom_range(0, 31)));
					default: write_reg(REG_REGION_BASE, random_word());
				endcase
			end
		end
	endtask

	task automatic random_config();
		logic [PATTERN_BITS-1:0] pattern;
		logic [63:0] mask;
		logic [63:0] len;
		logic [63:0] base;
		pattern = {random_word(), random_word()};
		case ($urandom_range(0, 9))
			0: pattern = '0;
			1: pattern = '1;
			default: ;
		endcase
		case ($urandom_range(0, 9))
			0: mask = '0;
			1: mask = 64'hFFFF;
			2: mask = random_word();
			default: mask = 64'($urandom & $urandom & $urandom);
		endcase
		case ($urandom_range(0, 9))
			0: len = 64'd0;
			1: len = 64'd16;
			2: len = 64'($urandom_range(17, 31));
			3: len = 64'd1;
			default: len = 64'($urandom_range(2, 6));
		endcase
		// upper bits of the length write fall outside the register
		if ($urandom_range(0, 4) == 0)
			len = (random_word() << LENGTH_BITS) | len;
		case ($urandom_range(0, 7))
			0: base = '0;
			1: base = '1;
			2: base = 64'hFFFF_FFFF_FFFF_FFF8;
			default: base = random_word();
		endcase
		load_search(pattern, mask, len, base);
	endtask

	task automatic run_random_phase(input int gap, input int stall, input int byte_goal);
		int start_count;
		int regions;
		int len;
		int rl;
		int pos;
		int pick;
		int split_at;
		gap_pct = gap;
		stall_pct = stall;
		start_count = bytes_sent;
		regions = 0;
		while (bytes_sent - start_count < byte_goal) begin
			if (regions % 6 == 0)
				random_config();
			else if (regions % 10 == 5)
				drain_results();  // hold the sender until every report is back
			len = active_length();
			rl = ($urandom_range(0, 9) == 0) ? $urandom_range(len, len + 60)
				: $urandom_range(1, len + 12);
			// filler leans on pattern bytes to provoke near misses
			region_buf.delete();
			for (int i = 0; i < rl; i++) begin
				pick = $urandom_range(0, len - 1);
				region_buf.insert(region_buf.size(), $urandom_range(0, 1) ? 8'($urandom)
					: pattern_shadow[8*pick +: 8]);
			end
			// plant a full occurrence in most regions long enough to hold one
			if (rl >= len && $urandom_range(0, 9) < 7) begin
				pos = $urandom_range(0, rl - len);
				for (int j = 0; j < len; j++)
					if (!mask_shadow[j])
						region_buf[pos + j] = pattern_shadow[8*j +: 8];
			end
			no_gap = ($urandom_range(0, 4) == 0);
			split_at = (rl > 1 && $urandom_range(0, 19) == 0) ? $urandom_range(0, rl - 2) : -1;
			send_region(split_at);
			no_gap = 1'b0;
			regions++;
		end
	endtask

	// Reset values: length one, pattern byte zero, base zero.
	task automatic test_reset_state();
		region_buf = '{8'h5A, 8'h00, 8'hFF};
		send_region(-1);
		region_buf = '{8'hFF};
		send_region(-1);
	endtask

	// Three-byte pattern with extreme bytes, matched by the final window of the region.
	task automatic test_exact_match();
		load_search(128'h80_FF_00, 64'd0, 64'd3, 64'h1000);
		region_buf = '{8'h11, 8'h00, 8'hFF, 8'h80};
		send_region(-1);
	endtask

	// Zero length acts as one; mask bits past the length do nothing; bytes after a match drop.
	task automatic test_wildcards();
		load_search(128'hFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 64'h20);
		region_buf = '{8'h01, 8'hFF, 8'h02, 8'hFF};
		send_region(-1);
	endtask

	// Length past the maximum clamps to sixteen; a region shorter than that ends not found.
	task automatic test_length_limits();
		load_search({random_word(), random_word()}, 64'd0, 64'd17, 64'd0);
		region_buf = '{8'h00, 8'hFF, 8'h5A};
		send_region(-1);
	endtask

	// Wildcard first byte, and a base at the top of the address space that wraps.
	task automatic test_address_wrap();
		load_search(128'h7F_00, 64'd1, 64'd2, '1);
		region_buf = '{8'h00, 8'h33, 8'h7F};
		send_region(-1);
	endtask

	// Change the pattern in the middle of a region; the new one applies to the next byte.
	task automatic test_config_mid_region();
		load_search(128'hAA, 64'd0, 64'd1, 64'h40);
		send_byte(8'h55, 1'b0);
		send_byte(8'h55, 1'b0);
		drain_results();
		write_reg(REG_PATTERN_LOW, 64'h55);
		send_byte(8'h55, 1'b1);
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, 475);
		run_random_phase(87, 0, 475);
		run_random_phase(0, 87, 475);
		run_random_phase(34, 34, 475);
	endtask

	initial begin
		clear_region_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_exact_match();
		test_wildcards();
		test_length_limits();
		test_address_wrap();
		test_config_mid_region();
		test_random_traffic();
		drain_results();
		if (mismatch_count == 0 && expected_reports.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
